// ===== src/ascii_number_parser_core_defines.svh =====
// Assertion macros for the ASCII number parser.
`ifndef ASCII_NUMBER_PARSER_CORE_DEFINES_SVH
`define ASCII_NUMBER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ANP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ANP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/anp_pkg.sv =====
// Shared types, constants and digit decode for the ASCII number parser.
`default_nettype none

package anp_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned OUT_COUNT_WIDTH = 16;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LOW_X = 8'h78;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_F = 8'h66;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ZERO,
    PH_X,
    PH_DEC,
    PH_HEX,
    PH_START
  } phase_e;

  typedef struct packed {
    logic   emit;
    logic   hex;
    phase_e phase;
  } step_ctl_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t dec_digit(input logic [7:0] b);
    digit_t d;
    d.ok  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    d.val = 4'(b - CHAR_ZERO);
    return d;
  endfunction

  function automatic digit_t hex_digit(input logic [7:0] b);
    digit_t d;
    d = dec_digit(b);
    if (!d.ok) begin
      if ((b >= CHAR_LOW_A) && (b <= CHAR_LOW_F)) begin
        d.ok  = 1'b1;
        d.val = 4'(b - CHAR_LOW_A) + 4'd10;
      end else if ((b >= CHAR_UP_A) && (b <= CHAR_UP_F)) begin
        d.ok  = 1'b1;
        d.val = 4'(b - CHAR_UP_A) + 4'd10;
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/anp_step.sv =====
// One parse step: next phase, value and count for a byte, and the emit decision.
`default_nettype none

module anp_step #(
  parameter int unsigned CountWidth = anp_pkg::COUNT_WIDTH
) (
  input  wire logic [7:0]                        byte_i,
  input  wire logic                              first_i,
  input  wire logic                              last_i,
  input  wire anp_pkg::phase_e                   phase_i,
  input  wire logic [anp_pkg::VALUE_WIDTH-1:0]   value_i,
  input  wire logic [CountWidth-1:0]             count_i,
  output anp_pkg::step_ctl_t                     ctl_o,
  output logic      [anp_pkg::VALUE_WIDTH-1:0]   value_o,
  output logic      [CountWidth-1:0]             count_o
);

  anp_pkg::phase_e                 ph;
  anp_pkg::digit_t                 dd;
  anp_pkg::digit_t                 hd;
  logic [anp_pkg::VALUE_WIDTH-1:0] val_base;
  logic [anp_pkg::VALUE_WIDTH-1:0] dec_next;
  logic [anp_pkg::VALUE_WIDTH-1:0] hex_next;
  logic [CountWidth-1:0]           cnt_base;
  logic [CountWidth-1:0]           cnt_inc;

  always_comb begin
    ph       = first_i ? anp_pkg::PH_START : phase_i;
    val_base = first_i ? '0 : value_i;
    cnt_base = first_i ? '0 : count_i;
    dd       = anp_pkg::dec_digit(byte_i);
    hd       = anp_pkg::hex_digit(byte_i);
    dec_next = (val_base << 3) + (val_base << 1)
             + anp_pkg::VALUE_WIDTH'(dd.val);
    hex_next = {val_base[anp_pkg::VALUE_WIDTH-5:0], hd.val};
    cnt_inc  = (&cnt_base) ? cnt_base : cnt_base + CountWidth'(1);

    ctl_o.emit  = 1'b0;
    ctl_o.hex   = 1'b0;
    ctl_o.phase = ph;
    value_o     = val_base;
    count_o     = cnt_base;

    unique case (ph)
      anp_pkg::PH_START: begin
        if (byte_i == anp_pkg::CHAR_ZERO) begin
          count_o     = CountWidth'(1);
          ctl_o.phase = anp_pkg::PH_ZERO;
          ctl_o.emit  = last_i;
        end else if (dd.ok) begin
          value_o     = anp_pkg::VALUE_WIDTH'(dd.val);
          count_o     = CountWidth'(1);
          ctl_o.phase = anp_pkg::PH_DEC;
          ctl_o.emit  = last_i;
        end else begin
          ctl_o.emit = 1'b1;
        end
      end
      anp_pkg::PH_ZERO: begin
        if (byte_i == anp_pkg::CHAR_LOW_X) begin
          ctl_o.phase = anp_pkg::PH_X;
          ctl_o.emit  = last_i;
        end else if (dd.ok) begin
          value_o     = dec_next;
          count_o     = cnt_inc;
          ctl_o.phase = anp_pkg::PH_DEC;
          ctl_o.emit  = last_i;
        end else begin
          ctl_o.emit = 1'b1;
        end
      end
      anp_pkg::PH_X: begin
        ctl_o.hex = 1'b1;
        if (hd.ok) begin
          value_o     = anp_pkg::VALUE_WIDTH'(hd.val);
          count_o     = CountWidth'(3);
          ctl_o.phase = anp_pkg::PH_HEX;
          ctl_o.emit  = last_i;
        end else begin
          count_o    = CountWidth'(2);
          ctl_o.emit = 1'b1;
        end
      end
      anp_pkg::PH_DEC: begin
        if (dd.ok) begin
          value_o    = dec_next;
          count_o    = cnt_inc;
          ctl_o.emit = last_i;
        end else begin
          ctl_o.emit = 1'b1;
        end
      end
      anp_pkg::PH_HEX: begin
        ctl_o.hex = 1'b1;
        if (hd.ok) begin
          value_o    = hex_next;
          count_o    = cnt_inc;
          ctl_o.emit = last_i;
        end else begin
          ctl_o.emit = 1'b1;
        end
      end
      default: begin
        ctl_o.phase = anp_pkg::PH_IDLE;
      end
    endcase

    if (ctl_o.emit) begin
      ctl_o.phase = anp_pkg::PH_IDLE;
    end
  end

endmodule

`default_nettype wire

// ===== src/ascii_number_parser_core.sv =====
// ASCII integer parser: decimal or 0x-prefixed hex, one byte per word, top level.
//
// Input stream: one ASCII byte per word in s_axis_tdata_i, tuser marks the
// first byte of a parse, tlast the last byte of the region. A parse that
// begins with "0x" and has a third byte is read as hex, otherwise decimal.
// It ends at the first non-digit (that byte is dropped) or at the last byte.
// Output stream: one word per finished parse with the value (mod 2^64) and the
// saturating count of consumed bytes in tdata, and the hex flag in tuser.
// Bytes after a finished parse are dropped until the next first mark; a first
// mark during a parse abandons it without output.
// Throughput: one byte per cycle while the receiver does not stall. The byte is
// held in an input register, and the step logic (a 64-bit shift-add) updates the
// state and loads the output register that offers the result word.
// When the receiver stalls, the output word holds and the input register
// fills; tready drops only when both are occupied.
// Reset clears the parse state and both valid flags; no parse is active.
`default_nettype none

`include "ascii_number_parser_core_defines.svh"

module ascii_number_parser_core #(
  parameter int unsigned CountWidth = anp_pkg::COUNT_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] first_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [79:0] m_axis_tdata_o,   // [63:0] parsed_value, [79:64] consumed_count
  output      logic        m_axis_tuser_o    // [0] was_hex
);

  logic                            in_valid_q;
  logic [7:0]                      byte_q;
  logic                            first_q;
  logic                            last_q;
  anp_pkg::phase_e                 phase_q;
  logic [anp_pkg::VALUE_WIDTH-1:0] value_q;
  logic [CountWidth-1:0]           count_q;
  logic                            out_valid_q;
  logic [anp_pkg::VALUE_WIDTH-1:0] out_value_q;
  logic [anp_pkg::OUT_COUNT_WIDTH-1:0] out_count_q;
  logic                            out_hex_q;

  anp_pkg::step_ctl_t              ctl;
  logic [anp_pkg::VALUE_WIDTH-1:0] value_d;
  logic [CountWidth-1:0]           count_d;
  logic [CountWidth+anp_pkg::OUT_COUNT_WIDTH-1:0] count_ext;
  logic                            advance;
  logic                            step_en;
  logic                            in_acc;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step_en         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign count_ext       = {{anp_pkg::OUT_COUNT_WIDTH{1'b0}}, count_d};

  anp_step #(
    .CountWidth(CountWidth)
  ) u_step (
    .byte_i  (byte_q),
    .first_i (first_q),
    .last_i  (last_q),
    .phase_i (phase_q),
    .value_i (value_q),
    .count_i (count_q),
    .ctl_o   (ctl),
    .value_o (value_d),
    .count_o (count_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= anp_pkg::PH_IDLE;
      value_q     <= '0;
      count_q     <= '0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= step_en && ctl.emit;
      end
      if (step_en) begin
        phase_q <= ctl.phase;
        value_q <= value_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q  <= s_axis_tdata_i;
      first_q <= s_axis_tuser_i;
      last_q  <= s_axis_tlast_i;
    end
    if (step_en && ctl.emit) begin
      out_value_q <= value_d;
      out_count_q <= count_ext[anp_pkg::OUT_COUNT_WIDTH-1:0];
      out_hex_q   <= ctl.hex;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_count_q, out_value_q};
  assign m_axis_tuser_o  = out_hex_q;

  `ANP_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !advance,
    in_valid_q && $stable(byte_q) && $stable(first_q), "input word lost while stalled")
  `ANP_ASSERT_NOW(a_zero_state, clk_i, rst_ni, phase_q == anp_pkg::PH_ZERO,
    value_q == '0 && count_q == CountWidth'(1), "leading zero state inconsistent")
  `ANP_ASSERT_NOW(a_prefix_state, clk_i, rst_ni, phase_q == anp_pkg::PH_X,
    value_q == '0, "value nonzero after hex prefix")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the ASCII number parser core, stream in and stream out.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] data;
    logic       first_mark;
    logic       last_mark;
  } in_word_t;

  typedef struct packed {
    logic [63:0]                     value;
    logic [anp_pkg::COUNT_WIDTH-1:0] count;
    logic                            hex;
  } parse_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;    // [7:0] data_byte
  logic        s_axis_tuser_i = 1'b0;  // [0] first_byte
  logic        s_axis_tlast_i = 1'b0;  // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;         // [63:0] parsed_value, [79:64] consumed_count
  logic        m_axis_tuser_o;         // [0] was_hex

  in_word_t      word_q[$];
  parse_result_t parsed_q[$];

  // predictor state
  anp_pkg::phase_e                 ps_phase = anp_pkg::PH_IDLE;
  logic [63:0]                     ps_value = '0;
  logic [anp_pkg::COUNT_WIDTH-1:0] ps_count = '0;

  int            send_idle_pct = 7;
  int            recv_idle_pct = 56;
  int            mismatches = 0;
  logic          stall_req = 1'b0;
  logic          stall_taken = 1'b0;
  int            stall_left = 0;
  in_word_t      next_word;
  parse_result_t accepted_result;
  parse_result_t want;

  ascii_number_parser_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string msg);
    if (mismatches < 50) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // {ok, value} of one byte as a digit
  function automatic logic [4:0] digit_of(input logic [7:0] b, input bit allow_hex);
    if (b >= anp_pkg::CHAR_ZERO && b <= anp_pkg::CHAR_NINE) begin
      return {1'b1, 4'(b - anp_pkg::CHAR_ZERO)};
    end
    if (allow_hex && b >= anp_pkg::CHAR_LOW_A && b <= anp_pkg::CHAR_LOW_F) begin
      return {1'b1, 4'(b - anp_pkg::CHAR_LOW_A + 8'd10)};
    end
    if (allow_hex && b >= anp_pkg::CHAR_UP_A && b <= anp_pkg::CHAR_UP_F) begin
      return {1'b1, 4'(b - anp_pkg::CHAR_UP_A + 8'd10)};
    end
    return 5'd0;
  endfunction

  function automatic void bump_count();
    if (ps_count != '1) ps_count++;
  endfunction

  // Advances the parser by one accepted word; returns 1 when a result is due.
  function automatic bit advance_parser(input in_word_t w, output parse_result_t r);
    anp_pkg::phase_e ph;
    logic [4:0]      d;
    bit              hex_sel;
    bit              done;
    ph = ps_phase;
    hex_sel = 1'b0;
    done = 1'b0;
    r = '0;
    if (w.first_mark) begin
      ps_value = '0;
      ps_count = '0;
      ph = anp_pkg::PH_START;
    end
    case (ph)
      anp_pkg::PH_START: begin
        d = digit_of(w.data, 1'b0);
        if (w.data == anp_pkg::CHAR_ZERO) begin
          ps_count = anp_pkg::COUNT_WIDTH'(1);
          ps_phase = anp_pkg::PH_ZERO;
          done = w.last_mark;
        end else if (!d[4]) begin
          done = 1'b1;
        end else begin
          ps_value = 64'(d[3:0]);
          ps_count = anp_pkg::COUNT_WIDTH'(1);
          ps_phase = anp_pkg::PH_DEC;
          done = w.last_mark;
        end
      end
      anp_pkg::PH_ZERO: begin
        d = digit_of(w.data, 1'b0);
        if (w.data == anp_pkg::CHAR_LOW_X) begin
          if (w.last_mark) done = 1'b1;
          else ps_phase = anp_pkg::PH_X;
        end else if (!d[4]) begin
          done = 1'b1;
        end else begin
          ps_value = ps_value * 64'd10 + 64'(d[3:0]);
          bump_count();
          ps_phase = anp_pkg::PH_DEC;
          done = w.last_mark;
        end
      end
      anp_pkg::PH_X: begin
        hex_sel = 1'b1;
        ps_count = anp_pkg::COUNT_WIDTH'(2);
        d = digit_of(w.data, 1'b1);
        if (!d[4]) begin
          done = 1'b1;
        end else begin
          ps_value = 64'(d[3:0]);
          bump_count();
          ps_phase = anp_pkg::PH_HEX;
          done = w.last_mark;
        end
      end
      anp_pkg::PH_DEC: begin
        d = digit_of(w.data, 1'b0);
        if (!d[4]) begin
          done = 1'b1;
        end else begin
          ps_value = ps_value * 64'd10 + 64'(d[3:0]);
          bump_count();
          done = w.last_mark;
        end
      end
      anp_pkg::PH_HEX: begin
        hex_sel = 1'b1;
        d = digit_of(w.data, 1'b1);
        if (!d[4]) begin
          done = 1'b1;
        end else begin
          ps_value = (ps_value << 4) + 64'(d[3:0]);
          bump_count();
          done = w.last_mark;
        end
      end
      default: ps_phase = anp_pkg::PH_IDLE;
    endcase
    if (done) begin
      r.value = ps_value;
      r.count = ps_count;
      r.hex = hex_sel;
      ps_phase = anp_pkg::PH_IDLE;
    end
    return done;
  endfunction

  function automatic void push_word(input logic [7:0] b, input bit f, input bit l);
    word_q.push_back('{data: b, first_mark: f, last_mark: l});
  endfunction

  function automatic void push_region(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      push_word(s[i], i == 0, close && (i == s.len() - 1));
    end
  endfunction

  // One random region: mostly well-formed numbers, some noise and broken ones.
  function automatic int push_random_region();
    logic [7:0] txt[$];
    logic [7:0] c;
    int         n;
    int         kind;
    int         ending;
    int         d;
    bit         close;
    kind = $urandom_range(0, 9);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
    ending = $urandom_range(0, 3);
    if (kind >= 3 && kind <= 5) begin
      txt.push_back(anp_pkg::CHAR_ZERO);
      txt.push_back(anp_pkg::CHAR_LOW_X);
      if ($urandom_range(0, 7) == 0) n = 0;
    end else if (kind == 6) begin
      txt.push_back(anp_pkg::CHAR_ZERO);
    end else if (kind == 8) begin
      txt.push_back(anp_pkg::CHAR_ZERO);
      txt.push_back(anp_pkg::CHAR_LOW_X);
      n = 0;
      ending = 0;
    end
    for (int i = 0; i < n; i++) begin
      d = $urandom_range(0, 15);
      if (kind == 7) begin
        c = 8'($urandom_range(0, 255));
      end else if (kind >= 3 && kind <= 5) begin
        if (d < 10) begin
          c = anp_pkg::CHAR_ZERO + 8'(d);
        end else begin
          c = (($urandom_range(0, 1) != 0) ? anp_pkg::CHAR_UP_A : anp_pkg::CHAR_LOW_A)
            + 8'(d - 10);
        end
      end else begin
        c = anp_pkg::CHAR_ZERO + 8'(d % 10);
      end
      txt.push_back(c);
    end
    if (ending == 2) begin
      // bytes just outside the digit ranges, an x or a random byte
      case ($urandom_range(0, 7))
        0: c = 8'h2F;
        1: c = 8'h3A;
        2: c = 8'h40;
        3: c = 8'h47;
        4: c = 8'h60;
        5: c = 8'h67;
        6: c = anp_pkg::CHAR_LOW_X;
        default: c = 8'($urandom_range(0, 255));
      endcase
      txt.push_back(c);
    end
    close = (ending < 2) || (ending == 2 && $urandom_range(0, 1) != 0);
    for (int i = 0; i < txt.size(); i++) begin
      push_word(txt[i], i == 0, close && (i == txt.size() - 1));
    end
    if (ending == 2 || $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 3)) begin
        push_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
    end
    return txt.size();
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
      s_axis_tuser_i <= 1'b0;
      s_axis_tlast_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (advance_parser({s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i}, accepted_result)) begin
          parsed_q.push_back(accepted_result);
        end
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = word_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= next_word.data;
          s_axis_tuser_i <= next_word.first_mark;
          s_axis_tlast_i <= next_word.last_mark;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= 0;
      stall_taken <= 1'b0;
    end else if (stall_req && !stall_taken) begin
      stall_left <= 400;
      stall_taken <= 1'b1;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (parsed_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word value=%0h", m_axis_tdata_o[63:0]));
      end else begin
        want = parsed_q.pop_front();
        if (m_axis_tdata_o[63:0] !== want.value) begin
          flag_mismatch($sformatf("value %0h, want %0h", m_axis_tdata_o[63:0], want.value));
        end
        if (m_axis_tdata_o[79:64] !== want.count) begin
          flag_mismatch($sformatf("count %0d, want %0d", m_axis_tdata_o[79:64], want.count));
        end
        if (m_axis_tuser_o !== want.hex) begin
          flag_mismatch($sformatf("hex flag %0b, want %0b", m_axis_tuser_o, want.hex));
        end
      end
    end
  end

  initial begin
    int sent;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_region("0", 1'b1);
    push_region("9", 1'b1);
    push_region("A", 1'b1);
    push_region("0x", 1'b1);
    push_region("0xg", 1'b1);
    push_region("0xfA9", 1'b1);
    push_region("12", 1'b0);
    push_region("3", 1'b1);
    push_region("7/", 1'b0);
    push_word(8'hFF, 1'b0, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    push_region("0X1", 1'b1);
    push_region("05", 1'b1);

    sent = 0;
    while (sent < 620) sent += push_random_region();
    while (word_q.size() != 0) @(posedge clk_i);

    send_idle_pct = 56;
    recv_idle_pct = 7;
    sent = 0;
    while (sent < 630) sent += push_random_region();
    while (word_q.size() != 0) @(posedge clk_i);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent = 0;
    while (sent < 630) sent += push_random_region();
    @(posedge clk_i);
    stall_req <= 1'b1;

    while (word_q.size() != 0 || s_axis_tvalid_i || parsed_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (parsed_q.size() != 0) flag_mismatch("results still outstanding");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/anp_pkg.sv
src/anp_step.sv
src/ascii_number_parser_core.sv
dv/tb_top.sv
